// ===== sv/mhs_pkg.sv =====
// Shared constants and types for the streaming MurmurHash2 core.
package mhs_pkg;

  localparam logic [31:0] MIX_MUL   = 32'h5bd1_e995;
  localparam int unsigned MIX_SHIFT = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TAIL,
    KIND_FULL
  } kind_e;

  typedef struct packed {
    logic        first;
    logic        last;
    kind_e       kind;
    logic [31:0] operand;
    logic [31:0] init;
  } q_entry_t;

endpackage

// ===== sv/murmur2_hash_stream_core.sv =====
// Streaming 32-bit MurmurHash2 core: front end, queue, back end.
// Throughput: one beat per cycle while the queue and back end do not stall; the back end's
// multiply-xor loop folds each beat into the running hash, and a last beat holds the back
// end in the finalizer multiply (S_FIN) and result register (S_OUT) states, longer while
// an earlier result beat is stalled.
// Reset clears the seed to zero, the message state and all valid flags.
module murmur2_hash_stream_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_data_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        is_last_i,
  input  logic [31:0] msg_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);
  import mhs_pkg::*;

  logic     full;
  logic     empty;
  logic     push;
  logic     pop;
  q_entry_t push_data;
  q_entry_t head;

  assign cfg_ready_o = 1'b1;

  mhs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .hash_seed_i   (hash_seed_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .word_data_i   (word_data_i),
    .valid_bytes_i (valid_bytes_i),
    .is_last_i     (is_last_i),
    .msg_len_i     (msg_len_i),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  mhs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  mhs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

// ===== sv/mhs_front.sv =====
// Front end: accepts beats, classifies them and premixes full words into the queue.
module mhs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [31:0]       hash_seed_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       word_data_i,
  input  logic [2:0]        valid_bytes_i,
  input  logic              is_last_i,
  input  logic [31:0]       msg_len_i,
  input  logic              full_i,
  output logic              push_o,
  output mhs_pkg::q_entry_t push_data_o
);
  import mhs_pkg::*;

  logic        seed_q;
  logic [31:0] seed_val_q;
  logic        in_msg_q;
  logic        s1_vld_q;
  logic        s2_vld_q;
  q_entry_t    s1_q;
  q_entry_t    s2_q;
  q_entry_t    s1_d;
  q_entry_t    s2_d;
  logic        s1_move;
  logic        s2_move;
  logic [31:0] mixed;

  assign s2_move     = !s2_vld_q || !full_i;
  assign s1_move     = !s1_vld_q || s2_move;
  assign in_stall_o  = s1_vld_q && !s2_move;
  assign push_o      = s2_vld_q && !full_i;
  assign push_data_o = s2_q;

  always_comb begin
    s1_d       = '0;
    s1_d.first = !in_msg_q;
    s1_d.last  = is_last_i;
    s1_d.init  = seed_val_q ^ msg_len_i;
    case (valid_bytes_i)
      3'd0: begin
        s1_d.kind    = KIND_NONE;
        s1_d.operand = '0;
      end
      3'd1: begin
        s1_d.kind    = KIND_TAIL;
        s1_d.operand = {24'd0, word_data_i[7:0]};
      end
      3'd2: begin
        s1_d.kind    = KIND_TAIL;
        s1_d.operand = {16'd0, word_data_i[15:0]};
      end
      3'd3: begin
        s1_d.kind    = KIND_TAIL;
        s1_d.operand = {8'd0, word_data_i[23:0]};
      end
      default: begin
        s1_d.kind    = KIND_FULL;
        s1_d.operand = word_data_i * MIX_MUL;
      end
    endcase
  end

  always_comb begin
    mixed = s1_q.operand ^ (s1_q.operand >> MIX_SHIFT);
    s2_d  = s1_q;
    if (s1_q.kind == KIND_FULL) begin
      s2_d.operand = mixed * MIX_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= 1'b0;
      seed_val_q <= '0;
      in_msg_q   <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s1_q       <= '0;
      s2_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        seed_q     <= 1'b1;
        seed_val_q <= hash_seed_i;
      end
      if (s1_move) begin
        s1_vld_q <= in_valid_i;
        if (in_valid_i) begin
          s1_q     <= s1_d;
          in_msg_q <= !is_last_i;
        end
      end
      if (s2_move) begin
        s2_vld_q <= s1_vld_q;
        if (s1_vld_q) begin
          s2_q <= s2_d;
        end
      end
    end
  end

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q)
    else $error("front stalls with empty first stage");

  a_push_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> s2_vld_q && !full_i)
    else $error("push without a ready second stage");

  a_seed_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> seed_q)
    else $error("seed write not recorded");

endmodule

// ===== sv/mhs_fifo.sv =====
// Short queue between front and back ends.
module mhs_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mhs_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output mhs_pkg::q_entry_t pop_data_o,
  output logic              empty_o
);
  import mhs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q;
  logic [AW-1:0]   rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ===== sv/mhs_back.sv =====
// Back end: carries the running hash, applies the finalizer and holds the result beat.
module mhs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  mhs_pkg::q_entry_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       hash_value_o
);
  import mhs_pkg::*;

  typedef enum logic [1:0] {
    S_RUN,
    S_FIN,
    S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] h_q;
  logic [31:0] p_q;
  logic [31:0] hash_q;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        out_load;
  logic [31:0] h0;
  logic [31:0] h_d;
  logic [31:0] p_d;

  assign pop_o        = (state_q == S_RUN) && !empty_i;
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  always_comb begin
    h0 = head_i.first ? head_i.init : h_q;
    case (head_i.kind)
      KIND_FULL: h_d = (h0 * MIX_MUL) ^ head_i.operand;
      KIND_TAIL: h_d = (h0 ^ head_i.operand) * MIX_MUL;
      default:   h_d = h0;
    endcase
    p_d         = (h_q ^ (h_q >> FIN_SHIFT_A)) * MIX_MUL;
    out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      h_q         <= '0;
      p_q         <= '0;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_RUN: begin
          if (!empty_i) begin
            h_q <= h_d;
            if (head_i.last) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          p_q     <= p_d;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            hash_q  <= p_q ^ (p_q >> FIN_SHIFT_B);
            state_q <= S_RUN;
          end
        end
        default: begin
          state_q <= S_RUN;
        end
      endcase
    end
  end

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result beat without finalize");

  a_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_RUN)
    else $error("queue pop outside run state");

endmodule
